FILE: hdl/chunk_pool_allocator_assert.svh
// Assertion macros for the chunk pool allocator.
`ifndef CHUNK_POOL_ALLOCATOR_ASSERT_SVH
`define CHUNK_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cpa_pkg.sv
// Shared constants and codes of the chunk pool allocator.
`default_nettype none
package cpa_pkg;

  localparam int CHUNK_BYTES = 32;
  localparam int NUM_CHUNKS  = 1024;

  localparam int REQ_W  = 2;
  localparam int SIZE_W = 16;
  localparam int ADDR_W = 15;
  localparam int ST_W   = 2;
  // operand of the chunk-count multiply: size plus rounding term
  localparam int DIV_W  = SIZE_W + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_REALLOC = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_BADADDR = 2'd2
  } status_e;

endpackage
`default_nettype wire

FILE: hdl/chunk_pool_allocator.sv
// First-fit chunk pool allocator: one module with sequencer, reciprocal multiply and tables.
`default_nettype none
// The pool is NUM_CHUNKS chunks of CHUNK_BYTES bytes. Requests (tuser: 0 allocate,
// 1 free, 2 reallocate) are taken one at a time; s_axis_tready is high only while the
// block is idle. After reset a clearing pass over all NUM_CHUNKS chunks runs before the
// first request is taken. Address and size are turned into chunk counts by a multiply
// with the constant reciprocal of CHUNK_BYTES. The first-fit search reads the busy
// bitmap one chunk per cycle. An allocate marks the granted run busy, or answers no
// room. A free releases its run; a reallocate keeps its address when the new size is
// below the old one, else it takes a new run and then releases the old one. A result
// waits in the output register while the next request is taken.
module chunk_pool_allocator #(
  parameter int CHUNK_BYTES = cpa_pkg::CHUNK_BYTES,
  parameter int NUM_CHUNKS  = cpa_pkg::NUM_CHUNKS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [15:0] size_bytes, [30:16] block_addr, [31] zero
  input  wire logic [31:0] s_axis_tdata_i,
  // [1:0] req_type
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [14:0] result_addr, [15] zero
  output logic [15:0]      m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]       m_axis_tuser_o
);

  localparam int XW  = $clog2(NUM_CHUNKS);
  localparam int IW  = $clog2(NUM_CHUNKS + 1);
  localparam int RW  = IW;
  localparam int DW  = cpa_pkg::DIV_W;
  localparam int SW  = cpa_pkg::SIZE_W;
  localparam int AW  = cpa_pkg::ADDR_W;
  // floor(x / CHUNK_BYTES) = (x * RECIP) >> SHF, exact for any x below 2**DW
  localparam int CLW = $clog2(CHUNK_BYTES);
  localparam int SHF = DW + CLW;
  localparam int MW  = DW + 1;
  localparam int PW  = DW + MW;
  localparam longint RECIP_L = ((longint'(1) << SHF) + longint'(CHUNK_BYTES) - 1)
                               / longint'(CHUNK_BYTES);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIVA, S_CHKA, S_RDRUN, S_LOOK, S_DIVS, S_CHKS, S_SCAN, S_MARK,
    S_REL, S_DONE
  } state_e;

  state_e              state_q, state_d;
  cpa_pkg::req_e       req_q, req_d;
  logic [SW-1:0]       size_q, size_d;
  logic [DW-1:0]       dvd_q, dvd_d, quo_q, quo_d, quo_nx;
  logic [XW-1:0]       idx_q, idx_d, start_q, start_d, mk_q, mk_d, clr_q, clr_d;
  logic [RW-1:0]       old_len_q, old_len_d, need_q, need_d, cnt_q, cnt_d, left_q, left_d;
  logic [IW-1:0]       scan_q, scan_d;
  logic                pv_q, pv_d;
  logic [AW-1:0]       fin_addr_q, fin_addr_d, out_addr_q, out_addr_d;
  cpa_pkg::status_e    fin_st_q, fin_st_d, out_st_q, out_st_d;
  logic                out_vld_q, out_vld_d;

  // chunk-count datapath
  logic [PW-1:0] prod;
  logic [PW-1:0] back;

  // memory ports
  logic          busy_we, busy_wd, busy_rd_q;
  logic [XW-1:0] busy_wa;
  logic          run_we;
  logic [XW-1:0] run_wa;
  logic [RW-1:0] run_wd, run_rd_q;
  logic          bytes_we;
  logic [SW-1:0] bytes_rd_q;

  logic [0:0]    busy_mem  [NUM_CHUNKS];
  logic [RW-1:0] run_mem   [NUM_CHUNKS];
  logic [SW-1:0] bytes_mem [NUM_CHUNKS];

  // input word fields
  logic [SW-1:0] in_size;
  logic [AW-1:0] in_addr;
  logic [SW-1:0] sz_src;

  assign in_size = s_axis_tdata_i[SW-1:0];
  assign in_addr = s_axis_tdata_i[SW+AW-1:SW];
  assign sz_src  = (state_q == S_IDLE) ? in_size : size_q;

  // quotient by reciprocal multiply, and the product back for the alignment check
  assign prod   = PW'(dvd_q) * PW'(RECIP);
  assign quo_nx = DW'(prod >> SHF);
  assign back   = PW'(quo_q) * PW'(CHUNK_BYTES);

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] s);
    logic [31:0] p;
    p = 32'(s) * 32'(CHUNK_BYTES);
    return p[AW-1:0];
  endfunction

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    size_d     = size_q;
    dvd_d      = dvd_q;
    quo_d      = quo_q;
    idx_d      = idx_q;
    start_d    = start_q;
    mk_d       = mk_q;
    clr_d      = clr_q;
    old_len_d  = old_len_q;
    need_d     = need_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    scan_d     = scan_q;
    pv_d       = pv_q;
    fin_addr_d = fin_addr_q;
    fin_st_d   = fin_st_q;
    out_addr_d = out_addr_q;
    out_st_d   = out_st_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    busy_we    = 1'b0;
    busy_wa    = mk_q;
    busy_wd    = 1'b0;
    run_we     = 1'b0;
    run_wa     = idx_q;
    run_wd     = '0;
    bytes_we   = 1'b0;

    case (state_q)
      S_CLEAR: begin
        busy_we = 1'b1;
        busy_wa = clr_q;
        run_we  = 1'b1;
        run_wa  = clr_q;
        clr_d   = clr_q + 1'b1;
        if (32'(clr_q) == NUM_CHUNKS - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          req_d  = cpa_pkg::req_e'(s_axis_tuser_i);
          size_d = in_size;
          case (cpa_pkg::req_e'(s_axis_tuser_i))
            cpa_pkg::REQ_ALLOC: begin
              if (in_size == '0) begin
                need_d  = RW'(1);
                scan_d  = '0;
                cnt_d   = '0;
                pv_d    = 1'b0;
                state_d = S_SCAN;
              end else begin
                dvd_d   = DW'(sz_src) + DW'(CHUNK_BYTES - 1);
                state_d = S_DIVS;
              end
            end
            cpa_pkg::REQ_FREE, cpa_pkg::REQ_REALLOC: begin
              dvd_d   = DW'(in_addr);
              state_d = S_DIVA;
            end
            default: begin
              fin_addr_d = '0;
              fin_st_d   = cpa_pkg::ST_OK;
              state_d    = S_DONE;
            end
          endcase
        end
      end
      S_DIVA: begin
        quo_d   = quo_nx;
        state_d = S_CHKA;
      end
      S_CHKA: begin
        // must be chunk aligned and inside the pool
        if (back != PW'(dvd_q) || 32'(quo_q) >= NUM_CHUNKS) begin
          fin_addr_d = '0;
          fin_st_d   = cpa_pkg::ST_BADADDR;
          state_d    = S_DONE;
        end else begin
          idx_d   = quo_q[XW-1:0];
          state_d = S_RDRUN;
        end
      end
      S_RDRUN: begin
        state_d = S_LOOK;
      end
      S_LOOK: begin
        old_len_d = run_rd_q;
        if (run_rd_q == '0) begin
          fin_addr_d = '0;
          fin_st_d   = cpa_pkg::ST_BADADDR;
          state_d    = S_DONE;
        end else if (req_q == cpa_pkg::REQ_FREE) begin
          mk_d    = idx_q;
          left_d  = run_rd_q;
          state_d = S_REL;
        end else if (bytes_rd_q > size_q) begin
          fin_addr_d = addr_of(idx_q);
          fin_st_d   = cpa_pkg::ST_OK;
          state_d    = S_DONE;
        end else if (size_q == '0) begin
          need_d  = RW'(1);
          scan_d  = '0;
          cnt_d   = '0;
          pv_d    = 1'b0;
          state_d = S_SCAN;
        end else begin
          dvd_d   = DW'(sz_src) + DW'(CHUNK_BYTES - 1);
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        quo_d   = quo_nx;
        state_d = S_CHKS;
      end
      S_CHKS: begin
        if (32'(quo_q) > NUM_CHUNKS) begin
          fin_addr_d = '0;
          fin_st_d   = cpa_pkg::ST_NOROOM;
          state_d    = S_DONE;
        end else begin
          need_d  = quo_q[RW-1:0];
          scan_d  = '0;
          cnt_d   = '0;
          pv_d    = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue the next bitmap read
        if (32'(scan_q) < NUM_CHUNKS) begin
          scan_d = scan_q + 1'b1;
          pv_d   = 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        // check the chunk read last cycle
        if (pv_q) begin
          if (busy_rd_q) begin
            cnt_d = '0;
          end else if (RW'(cnt_q + 1'b1) == need_q) begin
            start_d = XW'(scan_q - IW'(need_q));
            mk_d    = XW'(scan_q - IW'(need_q));
            left_d  = need_q;
            state_d = S_MARK;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else if (32'(scan_q) == NUM_CHUNKS) begin
          fin_addr_d = '0;
          fin_st_d   = cpa_pkg::ST_NOROOM;
          state_d    = S_DONE;
        end
      end
      S_MARK: begin
        busy_we = 1'b1;
        busy_wa = mk_q;
        busy_wd = 1'b1;
        if (left_q == need_q) begin
          run_we   = 1'b1;
          run_wa   = start_q;
          run_wd   = need_q;
          bytes_we = 1'b1;
        end
        mk_d   = mk_q + 1'b1;
        left_d = left_q - 1'b1;
        if (left_q == RW'(1)) begin
          if (req_q == cpa_pkg::REQ_REALLOC) begin
            mk_d    = idx_q;
            left_d  = old_len_q;
            state_d = S_REL;
          end else begin
            fin_addr_d = addr_of(start_q);
            fin_st_d   = cpa_pkg::ST_OK;
            state_d    = S_DONE;
          end
        end
      end
      S_REL: begin
        busy_we = 1'b1;
        busy_wa = mk_q;
        busy_wd = 1'b0;
        if (left_q == old_len_q) begin
          run_we = 1'b1;
          run_wa = idx_q;
          run_wd = '0;
        end
        mk_d   = mk_q + 1'b1;
        left_d = left_q - 1'b1;
        if (left_q == RW'(1)) begin
          fin_addr_d = (req_q == cpa_pkg::REQ_FREE) ? '0 : addr_of(start_q);
          fin_st_d   = cpa_pkg::ST_OK;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d  = 1'b1;
          out_addr_d = fin_addr_q;
          out_st_d   = fin_st_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      req_q      <= cpa_pkg::REQ_NONE;
      size_q     <= '0;
      dvd_q      <= '0;
      quo_q      <= '0;
      idx_q      <= '0;
      start_q    <= '0;
      mk_q       <= '0;
      clr_q      <= '0;
      old_len_q  <= '0;
      need_q     <= '0;
      cnt_q      <= '0;
      left_q     <= '0;
      scan_q     <= '0;
      pv_q       <= 1'b0;
      fin_addr_q <= '0;
      fin_st_q   <= cpa_pkg::ST_OK;
      out_addr_q <= '0;
      out_st_q   <= cpa_pkg::ST_OK;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      req_q      <= req_d;
      size_q     <= size_d;
      dvd_q      <= dvd_d;
      quo_q      <= quo_d;
      idx_q      <= idx_d;
      start_q    <= start_d;
      mk_q       <= mk_d;
      clr_q      <= clr_d;
      old_len_q  <= old_len_d;
      need_q     <= need_d;
      cnt_q      <= cnt_d;
      left_q     <= left_d;
      scan_q     <= scan_d;
      pv_q       <= pv_d;
      fin_addr_q <= fin_addr_d;
      fin_st_q   <= fin_st_d;
      out_addr_q <= out_addr_d;
      out_st_q   <= out_st_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // busy bitmap, read by the search
  always_ff @(posedge clk_i) begin
    if (busy_we) begin
      busy_mem[busy_wa] <= busy_wd;
    end
    busy_rd_q <= busy_mem[scan_q[XW-1:0]][0];
  end

  // run length at each start chunk
  always_ff @(posedge clk_i) begin
    if (run_we) begin
      run_mem[run_wa] <= run_wd;
    end
    run_rd_q <= run_mem[idx_q];
  end

  // byte size at each start chunk
  always_ff @(posedge clk_i) begin
    if (bytes_we) begin
      bytes_mem[start_q] <= size_q;
    end
    bytes_rd_q <= bytes_mem[idx_q];
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_addr_q};
  assign m_axis_tuser_o  = out_st_q;

`include "chunk_pool_allocator_assert.svh"

  `CPA_ASSERT_NOW(a_scan_cnt, state_q == S_SCAN, cnt_q < need_q, "run count reached need")
  `CPA_ASSERT_NOW(a_noroom_zero, out_vld_q && out_st_q == cpa_pkg::ST_NOROOM, out_addr_q == '0, "failed grant has nonzero address")
  `CPA_ASSERT_NEXT(a_done_out, state_q == S_DONE && (!out_vld_q || m_axis_tready_i), out_vld_q && state_q == S_IDLE, "finished result not presented")

endmodule
`default_nettype wire
